// ===== sv/tws_pkg.sv =====
// Shared types for the three-way merge sorter core.
// No dependencies; imported by the compare unit and the top level.
`default_nettype none

package tws_pkg;

    typedef struct packed {
        logic a_ok;
        logic b_ok;
    } t_cmp_ctl;

endpackage

`default_nettype wire

// ===== sv/tws_ram.sv =====
// Element memory with one write port and two registered read ports.
// No dependencies; instantiated twice by the top level as ping-pong buffers.
`default_nettype none

module tws_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== sv/tws_cmp.sv =====
// Shared compare-and-select unit used by every merge step.
// Depends on tws_pkg for the operand control struct.
`default_nettype none

module tws_cmp
    import tws_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire t_cmp_ctl         i_ctl,
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    output logic                  o_take_b,
    output logic      [WIDTH-1:0] o_data
);

    // The second run wins when the first is spent, else only when strictly smaller, keeping the merge stable.
    assign o_take_b = i_ctl.b_ok && (!i_ctl.a_ok || ($signed(i_b) < $signed(i_a)));
    assign o_data   = o_take_b ? i_b : i_a;

endmodule

`default_nettype wire

// ===== sv/three_way_merge_sorter_core.sv =====
// Load: one request per cycle while busy is low. Sort: ceil(log2 n) bottom-up merge passes,
// each element taking a read state (S_RD) then a compare state (S_CMP) in the single compare
// unit. Emit: n results, one per cycle, read through the registered RAM port and strobe.
// busy is high from the last request until the final result has been shown. Reset is
// synchronous and returns to an empty run.
`default_nettype none

module three_way_merge_sorter_core
    import tws_pkg::*;
#(
    parameter int MAX_ITEMS  = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_last,
    output logic                    o_strobe,
    output logic signed [31:0]      o_sorted_value,
    output logic                    o_last_out,
    output logic                    o_overflow
);

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SW    = CNT_W + 2;

    typedef enum logic [1:0] {S_LOAD, S_RD, S_CMP, S_EMIT} t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_drop, n_drop;
    logic             r_src, n_src;
    logic [CNT_W-1:0] r_w, n_w;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic             r_out_vld, n_out_vld;
    logic             r_out_last, n_out_last;
    logic             r_out_ovf, n_out_ovf;

    logic [VALUE_BITS-1:0] w_in_val;
    logic [VALUE_BITS-1:0] w_rd_a [2];
    logic [VALUE_BITS-1:0] w_rd_b [2];
    logic [VALUE_BITS-1:0] w_src_a, w_src_b;
    logic [VALUE_BITS-1:0] w_wdata;
    logic [AW-1:0]         w_waddr, w_raddr_a;
    logic [1:0]            w_we;
    logic                  w_accept, w_load_last, w_seg_done, w_pass_done;
    logic [CNT_W-1:0]      w_load_cnt, w_k_inc;
    logic [SW-1:0]         w_w2;
    logic [CNT_W-1:0]      w_seg_lo, w_seg_w, w_seg_n, w_seg_mid, w_seg_hi;
    logic [SW-1:0]         w_s1, w_s2;
    t_cmp_ctl              w_ctl;
    logic                  w_take_b;
    logic [VALUE_BITS-1:0] w_cmp_data;

    generate
        if (VALUE_BITS <= 32) begin : g_in_narrow
            assign w_in_val = i_value[VALUE_BITS-1:0];
        end else begin : g_in_wide
            assign w_in_val = {{(VALUE_BITS-32){1'b0}}, i_value};
        end
        if (VALUE_BITS >= 32) begin : g_out_wide
            assign o_sorted_value = w_src_a[31:0];
        end else begin : g_out_narrow
            assign o_sorted_value = {{(32-VALUE_BITS){1'b0}}, w_src_a};
        end
    endgenerate

    assign busy        = (r_state != S_LOAD) || r_out_vld;
    assign w_accept    = start && !busy;
    assign w_load_last = w_accept && i_last;
    assign w_load_cnt  = (r_cnt < CNT_W'(MAX_ITEMS)) ? r_cnt + 1'b1 : r_cnt;
    assign w_k_inc     = r_k + 1'b1;
    assign w_seg_done  = (r_state == S_CMP) && (w_k_inc == r_hi);
    assign w_pass_done = w_seg_done && (r_hi == r_cnt);
    assign w_w2        = {1'b0, r_w, 1'b0};

    assign w_src_a   = r_src ? w_rd_a[1] : w_rd_a[0];
    assign w_src_b   = r_src ? w_rd_b[1] : w_rd_b[0];
    assign w_raddr_a = (r_state == S_EMIT) ? r_k[AW-1:0] : r_i[AW-1:0];

    assign w_ctl.a_ok = (r_i < r_mid);
    assign w_ctl.b_ok = (r_j < r_hi);

    tws_cmp #(.WIDTH(VALUE_BITS)) u_cmp (
        .i_ctl   (w_ctl),
        .i_a     (w_src_a),
        .i_b     (w_src_b),
        .o_take_b(w_take_b),
        .o_data  (w_cmp_data)
    );

    always_comb begin
        w_seg_lo = r_hi;
        w_seg_w  = r_w;
        w_seg_n  = r_cnt;
        if (r_state == S_LOAD) begin
            w_seg_lo = '0;
            w_seg_w  = CNT_W'(1);
            w_seg_n  = w_load_cnt;
        end else if (w_pass_done) begin
            w_seg_lo = '0;
            w_seg_w  = w_w2[CNT_W-1:0];
        end
    end

    always_comb begin
        w_s1      = SW'(w_seg_lo) + SW'(w_seg_w);
        w_s2      = w_s1 + SW'(w_seg_w);
        w_seg_mid = (w_s1 < SW'(w_seg_n)) ? w_s1[CNT_W-1:0] : w_seg_n;
        w_seg_hi  = (w_s2 < SW'(w_seg_n)) ? w_s2[CNT_W-1:0] : w_seg_n;
    end

    always_comb begin
        w_we    = 2'b00;
        w_waddr = r_k[AW-1:0];
        w_wdata = w_cmp_data;
        if (r_state == S_LOAD) begin
            w_waddr = r_cnt[AW-1:0];
            w_wdata = w_in_val;
            w_we[0] = w_accept && (r_cnt < CNT_W'(MAX_ITEMS));
        end else if (r_state == S_CMP) begin
            w_we[!r_src] = 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_drop     = r_drop;
        n_src      = r_src;
        n_w        = r_w;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_mid      = r_mid;
        n_hi       = r_hi;
        n_out_vld  = 1'b0;
        n_out_last = r_out_last;
        n_out_ovf  = r_out_ovf;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    n_cnt  = w_load_cnt;
                    n_drop = r_drop || (r_cnt == CNT_W'(MAX_ITEMS));
                end
                if (w_load_last) begin
                    n_src = 1'b0;
                    n_w   = CNT_W'(1);
                    n_k   = '0;
                    n_i   = '0;
                    n_j   = w_seg_mid;
                    n_mid = w_seg_mid;
                    n_hi  = w_seg_hi;
                    n_state = (w_load_cnt <= CNT_W'(1)) ? S_EMIT : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_k = w_k_inc;
                if (w_take_b) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
                n_state = S_RD;
                if (w_seg_done) begin
                    n_i   = w_seg_lo;
                    n_j   = w_seg_mid;
                    n_mid = w_seg_mid;
                    n_hi  = w_seg_hi;
                end
                if (w_pass_done) begin
                    n_src = !r_src;
                    n_k   = '0;
                    n_w   = w_seg_w;
                    if (w_w2 >= SW'(r_cnt)) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                n_k        = w_k_inc;
                n_out_vld  = 1'b1;
                n_out_last = (w_k_inc == r_cnt);
                n_out_ovf  = r_drop;
                if (w_k_inc == r_cnt) begin
                    n_cnt   = '0;
                    n_drop  = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_drop    <= n_drop;
            r_out_vld <= n_out_vld;
        end
        r_src      <= n_src;
        r_w        <= n_w;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_mid      <= n_mid;
        r_hi       <= n_hi;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_strobe   = r_out_vld;
    assign o_last_out = r_out_last;
    assign o_overflow = r_out_ovf;

    generate
        for (genvar g = 0; g < 2; g++) begin : g_ram
            tws_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_BITS)) u_ram (
                .i_clk    (i_clk),
                .i_we     (w_we[g]),
                .i_waddr  (w_waddr),
                .i_wdata  (w_wdata),
                .i_raddr_a(w_raddr_a),
                .i_raddr_b(r_j[AW-1:0]),
                .o_rdata_a(w_rd_a[g]),
                .o_rdata_b(w_rd_b[g])
            );
        end
    endgenerate

endmodule

`default_nettype wire

// ===== sv/tws_checker.sv =====
// Port-level checks for the three-way merge sorter core.
// Depends on three_way_merge_sorter_core; attached to it by the bind below.
`default_nettype none

module tws_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic signed [31:0] i_value,
    input wire logic               i_last,
    input wire logic               o_strobe,
    input wire logic signed [31:0] o_sorted_value,
    input wire logic               o_last_out,
    input wire logic               o_overflow
);

    // A result never appears while new requests could be taken.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result shown while not busy");

    // Results of a run come on consecutive cycles until the last one.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_out |=> o_strobe && (o_overflow == $past(o_overflow)))
        else $error("run emission broken or overflow flag changed");

    // The last result ends the run.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_out |=> !o_strobe)
        else $error("result after last of run");

    // A request that does not close a run produces no result.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_last |=> !o_strobe && !busy)
        else $error("result or busy after non-final request");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("block not idle after reset");

endmodule

bind three_way_merge_sorter_core tws_checker u_tws_checker (.*);

`default_nettype wire
